@@ rtl/core/lrrb_pkg.sv @@
// Shared types and constants of the line replay ring buffer.
// No dependencies; imported by the controller, datapath and top level.
package lrrb_pkg;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_MARK   = 2'd1,
        OP_REPLAY = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Stored entry: bit 8 flags end-of-file, bits 7..0 hold the character.
    localparam int unsigned ENTRY_W = 9;
    localparam logic [ENTRY_W-1:0] NEWLINE_ENTRY = 9'h00A;
    localparam logic [ENTRY_W-1:0] EOF_ENTRY     = 9'h100;

    typedef struct packed {
        t_op        op;
        logic [7:0] line_char;
        logic       line_eof;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_eof;
        logic       from_replay;
        logic       line_taken;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic item_load;     // latch accepted item
        logic res_clear;     // result := all zero
        logic buf_clear;     // empty buffer, end replay
        logic replay_start;  // rewind replay to oldest entry
        logic replay_end;    // replay used up
        logic rd_replay;     // read entry at replay index, advance it
        logic rd_drop;       // read entry at oldest index
        logic drop_step;     // discard oldest entry
        logic res_replay;    // result := replayed entry
        logic wr_fresh;      // record fresh item, result := fresh item
        logic out_load;      // move result into output register
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        t_op  op;
        logic replay_active;
        logic replay_empty;
        logic count_zero;
        logic full;
        logic rd_eof;
        logic rd_newline;
        logic out_free;
    } t_status;

endpackage

@@ rtl/core/line_replay_ring_buffer.sv @@
// Top level of the line replay ring buffer: controller plus datapath.
// Depends on lrrb_pkg, lrrb_ctrl, lrrb_datapath (and lrrb_ram below it).
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------
//  in      | to block  | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  out     | from block| o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// From acceptance to a loaded result, mark, replay and the unused op pass
// the decode and final states; a fresh read adds the fullness check and
// the write, a replayed character a replay check and its evaluation, and a
// fresh read after a used-up replay a replay check and the fresh steps. Each
// entry walked, skipped as end-of-file in a replay or dropped on overflow,
// adds a store read and a check, as the store has a registered read port;
// a discard finding no newline adds one more step. A next item can be taken in the cycle after a load.
// Reset clears all indices, counts and the replay flag at once; the entry
// store is not cleared, as only written entries are ever read.
// A new item is taken only when the previous one is finished; a result
// held in the output register under stall does not block acceptance, only
// the loading of the next result.
module line_replay_ring_buffer #(
    parameter int unsigned BUFFER_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lrrb_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lrrb_pkg::t_out_item o_out_data
);
    import lrrb_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer: one item at a time, each store entry read in one state and checked in the next
    lrrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // indices, counts, entry store and the output register
    lrrb_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

    // A fresh item is never recorded into a full buffer.
    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.full |-> !w_cmd.wr_fresh)
        else $error("fresh item written into a full buffer");

    // The single read port serves either replay or discard, not both.
    a_one_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.rd_replay && w_cmd.rd_drop))
        else $error("two store reads in one cycle");

    // A result is loaded only when the output register can take it.
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_status.out_free)
        else $error("result loaded over a stalled output item");

    // An accepted item blocks the input in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after acceptance");

endmodule

@@ rtl/core/lrrb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lrrb_ram #(
    parameter int unsigned WIDTH = 9,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/lrrb_ctrl.sv @@
// Sequencing controller of the line replay ring buffer.
// Depends on lrrb_pkg; drives t_cmd from t_status.
module lrrb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lrrb_pkg::t_status i_status,
    output lrrb_pkg::t_cmd    o_cmd
);
    import lrrb_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE       = 9'b000000001,
        S_DECODE     = 9'b000000010,
        S_RP_CHECK   = 9'b000000100,
        S_RP_EVAL    = 9'b000001000,
        S_FRESH      = 9'b000010000,
        S_DROP_CHECK = 9'b000100000,
        S_DROP_EVAL  = 9'b001000000,
        S_WRITE      = 9'b010000000,
        S_FIN        = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.item_load = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                w_cmd.res_clear = 1'b1;
                unique case (i_status.op)
                    OP_READ:   n_state = i_status.replay_active ? S_RP_CHECK : S_FRESH;
                    OP_MARK: begin
                        w_cmd.buf_clear = 1'b1;
                        n_state         = S_FIN;
                    end
                    OP_REPLAY: begin
                        w_cmd.replay_start = 1'b1;
                        n_state            = S_FIN;
                    end
                    OP_NONE:   n_state = S_FIN;
                    default:   n_state = S_FIN;
                endcase
            end
            S_RP_CHECK: begin
                if (i_status.replay_empty) begin
                    w_cmd.replay_end = 1'b1;
                    n_state          = S_FRESH;
                end else begin
                    w_cmd.rd_replay = 1'b1;
                    n_state         = S_RP_EVAL;
                end
            end
            S_RP_EVAL: begin
                // stored end-of-file entries are skipped
                if (i_status.rd_eof) begin
                    n_state = S_RP_CHECK;
                end else begin
                    w_cmd.res_replay = 1'b1;
                    n_state          = S_FIN;
                end
            end
            S_FRESH: begin
                n_state = i_status.full ? S_DROP_CHECK : S_WRITE;
            end
            S_DROP_CHECK: begin
                if (i_status.count_zero) begin
                    w_cmd.buf_clear = 1'b1;
                    n_state         = S_WRITE;
                end else begin
                    w_cmd.rd_drop = 1'b1;
                    n_state       = S_DROP_EVAL;
                end
            end
            S_DROP_EVAL: begin
                w_cmd.drop_step = 1'b1;
                n_state         = i_status.rd_newline ? S_WRITE : S_DROP_CHECK;
            end
            S_WRITE: begin
                w_cmd.wr_fresh = 1'b1;
                n_state        = S_FIN;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = w_cmd;

endmodule

@@ rtl/core/lrrb_datapath.sv @@
// Indices, counters, entry store and output register of the ring buffer.
// Depends on lrrb_pkg and lrrb_ram; steered by t_cmd from lrrb_ctrl.
module lrrb_datapath #(
    parameter int unsigned BUFFER_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lrrb_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lrrb_pkg::t_out_item o_out_data,
    input  lrrb_pkg::t_cmd      i_cmd,
    output lrrb_pkg::t_status   o_status
);
    import lrrb_pkg::*;

    localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(BUFFER_DEPTH);

    t_in_item     r_item;
    logic [AW-1:0] r_oldest;
    logic [AW-1:0] r_insert;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_rp_idx;
    logic [CW-1:0] r_rp_rem;
    logic          r_rp_act;
    t_out_item     r_res;
    t_out_item     r_out;
    logic          r_out_valid;

    logic [ENTRY_W-1:0] w_rd_data;
    logic [ENTRY_W-1:0] w_wr_data;
    logic [AW-1:0]      w_rd_addr;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + AW'(1);
    endfunction

    assign w_rd_addr = i_cmd.rd_replay ? r_rp_idx : r_oldest;
    assign w_wr_data = r_item.line_eof ? EOF_ENTRY : {1'b0, r_item.line_char};

    lrrb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_fresh),
        .i_wr_addr (r_insert),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.rd_replay | i_cmd.rd_drop),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest    <= '0;
            r_insert    <= '0;
            r_count     <= '0;
            r_rp_idx    <= '0;
            r_rp_rem    <= '0;
            r_rp_act    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.buf_clear) begin
                r_oldest <= '0;
                r_insert <= '0;
                r_count  <= '0;
                r_rp_act <= 1'b0;
            end else if (i_cmd.drop_step) begin
                r_oldest <= next_slot(r_oldest);
                r_count  <= r_count - CW'(1);
            end else if (i_cmd.wr_fresh) begin
                r_insert <= next_slot(r_insert);
                r_count  <= r_count + CW'(1);
            end
            if (i_cmd.replay_start) begin
                r_rp_act <= 1'b1;
                r_rp_idx <= r_oldest;
                r_rp_rem <= r_count;
            end else if (i_cmd.replay_end) begin
                r_rp_act <= 1'b0;
            end else if (i_cmd.rd_replay) begin
                r_rp_idx <= next_slot(r_rp_idx);
                r_rp_rem <= r_rp_rem - CW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.res_clear) begin
            r_res <= '0;
        end else if (i_cmd.res_replay) begin
            r_res.out_char    <= w_rd_data[7:0];
            r_res.out_eof     <= 1'b0;
            r_res.from_replay <= 1'b1;
            r_res.line_taken  <= 1'b0;
        end else if (i_cmd.wr_fresh) begin
            r_res.out_char    <= r_item.line_eof ? 8'd0 : r_item.line_char;
            r_res.out_eof     <= r_item.line_eof;
            r_res.from_replay <= 1'b0;
            r_res.line_taken  <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    always_comb begin
        o_status               = '0;
        o_status.op            = r_item.op;
        o_status.replay_active = r_rp_act;
        o_status.replay_empty  = (r_rp_rem == '0);
        o_status.count_zero    = (r_count == '0);
        o_status.full          = (r_count >= FULL_CNT);
        o_status.rd_eof        = w_rd_data[ENTRY_W-1];
        o_status.rd_newline    = (w_rd_data == NEWLINE_ENTRY);
        o_status.out_free      = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench of line_replay_ring_buffer: directed then segmented random items,
// with a scoreboard class that predicts each result. Depends on lrrb_pkg.
module tb_top;

    import lrrb_pkg::*;

    localparam int unsigned BUF_DEPTH       = 256;
    localparam int unsigned CYCLE_LIMIT     = 5_000_000;
    localparam int unsigned HOLD_OFF_CYCLES = 500;
    localparam int unsigned ITEM_TARGET     = 600;
    localparam logic [7:0]  NEWLINE         = NEWLINE_ENTRY[7:0];

    // Kinds of random segment
    typedef enum int {
        SEG_MIXED,      // short, every op
        SEG_LINES,      // mark, long text with newlines, then replay
        SEG_UNBROKEN    // mark, long text without newline, then replay
    } t_segment;

    // Tracks the capture buffer and the items it should return.
    class echo_scoreboard;
        logic [ENTRY_W-1:0] entries [BUF_DEPTH];
        int unsigned        oldest;
        int unsigned        insert;
        int unsigned        count;
        int unsigned        replay_pos;
        int unsigned        replay_left;
        bit                 replaying;
        t_out_item          pending_echoes[$];
        int unsigned        errors;

        function new();
            wipe();
            replay_pos  = 0;
            replay_left = 0;
            errors      = 0;
        endfunction

        function int unsigned next_slot(int unsigned i);
            return (i + 1 >= BUF_DEPTH) ? 0 : i + 1;
        endfunction

        function void wipe();
            replaying = 1'b0;
            count     = 0;
            oldest    = 0;
            insert    = 0;
        endfunction

        function void log_accepted_item(t_in_item item);
            t_out_item          res;
            logic [ENTRY_W-1:0] entry;
            bit                 done;
            res  = '0;
            done = 1'b0;
            case (item.op)
                OP_MARK: begin
                    wipe();
                end
                OP_REPLAY: begin
                    replaying   = 1'b1;
                    replay_pos  = oldest;
                    replay_left = count;
                end
                OP_READ: begin
                    // replay: stored end-of-file entries are skipped
                    while (replaying && !done) begin
                        if (replay_left == 0) begin
                            replaying = 1'b0;
                        end else begin
                            entry       = entries[replay_pos];
                            replay_pos  = next_slot(replay_pos);
                            replay_left = replay_left - 1;
                            if (!entry[8]) begin
                                res.out_char    = entry[7:0];
                                res.from_replay = 1'b1;
                                done            = 1'b1;
                            end
                        end
                    end
                    if (!done) begin
                        // full: drop oldest line up to its newline, or all
                        if (count >= BUF_DEPTH) begin
                            while (count > 0 && entries[oldest] != NEWLINE_ENTRY) begin
                                oldest = next_slot(oldest);
                                count  = count - 1;
                            end
                            if (count == 0) begin
                                wipe();
                            end else begin
                                oldest = next_slot(oldest);
                                count  = count - 1;
                            end
                        end
                        count           = count + 1;
                        entries[insert] = item.line_eof ? EOF_ENTRY : {1'b0, item.line_char};
                        insert          = next_slot(insert);
                        res.out_char    = item.line_eof ? 8'h00 : item.line_char;
                        res.out_eof     = item.line_eof;
                        res.line_taken  = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            pending_echoes.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                errors = errors + 1;
            end
        endfunction

        function void check_output_item(t_out_item got);
            t_out_item want;
            if (pending_echoes.size() == 0) begin
                $error("output item 0x%0h with no item pending", got);
                errors = errors + 1;
                return;
            end
            want = pending_echoes.pop_front();
            compare_field("out_char", want.out_char, got.out_char);
            compare_field("out_eof", {7'd0, want.out_eof}, {7'd0, got.out_eof});
            compare_field("from_replay", {7'd0, want.from_replay}, {7'd0, got.from_replay});
            compare_field("line_taken", {7'd0, want.line_taken}, {7'd0, got.line_taken});
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    echo_scoreboard echoes;
    bit             eager_sender     = 1'b0;
    bit             hold_off_request = 1'b0;
    int unsigned    fed_items        = 0;
    int unsigned    cycles           = 0;

    line_replay_ring_buffer #(
        .BUFFER_DEPTH(BUF_DEPTH)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always #5 clk = ~clk;

    // Offer one item after a random gap and hold it until accepted.
    task automatic offer_item(input t_op op, input logic [7:0] ch, input logic eof);
        t_in_item    item;
        int unsigned gap;
        item.op        = op;
        item.line_char = ch;
        item.line_eof  = eof;
        gap = eager_sender ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        echoes.log_accepted_item(item);
    endtask

    // Sender: directed items, then random segments.
    initial begin
        int unsigned seg;
        int unsigned len;
        int unsigned r;
        t_segment    kind;
        t_op         op;
        logic [7:0]  ch;
        logic        eof;
        echoes = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes of the character, fresh end-of-file, the unused op
        offer_item(OP_READ, 8'h00, 1'b0);
        offer_item(OP_READ, 8'hFF, 1'b0);
        offer_item(OP_READ, 8'hA5, 1'b1);
        offer_item(OP_READ, NEWLINE, 1'b0);
        offer_item(OP_NONE, 8'hFF, 1'b1);
        // Replay: three chars, stored end-of-file skipped, then used up
        offer_item(OP_REPLAY, 8'h00, 1'b0);
        offer_item(OP_READ, 8'h11, 1'b1);
        offer_item(OP_READ, 8'h22, 1'b0);
        offer_item(OP_READ, 8'h33, 1'b0);
        offer_item(OP_READ, 8'h41, 1'b0);
        // Mark, then replay of an empty buffer
        offer_item(OP_MARK, 8'hFF, 1'b1);
        offer_item(OP_REPLAY, 8'h00, 1'b0);
        offer_item(OP_READ, 8'h7E, 1'b0);
        offer_item(OP_READ, 8'h00, 1'b1);
        // Replay ending on a stored end-of-file falls through to a fresh read
        offer_item(OP_REPLAY, 8'hFF, 1'b1);
        offer_item(OP_READ, 8'h80, 1'b0);
        offer_item(OP_READ, 8'h01, 1'b0);
        offer_item(OP_MARK, 8'h00, 1'b0);
        offer_item(OP_NONE, 8'h00, 1'b0);
        offer_item(OP_REPLAY, 8'hFF, 1'b1);

        seg = 0;
        while (fed_items < ITEM_TARGET) begin
            if (seg == 1 || (seg > 4 && $urandom_range(0, 5) == 0))
                kind = SEG_LINES;
            else if (seg == 3)
                kind = SEG_UNBROKEN;
            else
                kind = SEG_MIXED;
            eager_sender = ($urandom_range(0, 3) == 0);
            // receiver holds off while items keep coming
            if (seg == 2)
                hold_off_request = 1'b1;
            // let the block drain completely once
            if (seg == 3) begin
                in_valid <= 1'b0;
                while (echoes.pending_echoes.size() != 0) @(posedge clk);
            end
            case (kind)
                SEG_MIXED: begin
                    len = $urandom_range(5, 60);
                    repeat (len) begin
                        r  = $urandom_range(0, 99);
                        op = (r < 68) ? OP_READ : (r < 80) ? OP_REPLAY :
                             (r < 90) ? OP_MARK : OP_NONE;
                        ch  = ($urandom_range(0, 7) == 0) ? NEWLINE
                                                          : 8'($urandom_range(0, 255));
                        eof = ($urandom_range(0, 7) == 0);
                        offer_item(op, ch, eof);
                        if (op != OP_NONE)
                            fed_items = fed_items + 1;
                    end
                end
                default: begin
                    // long runs fill the buffer so that the overflow discard
                    // and the index wrap are reached
                    offer_item(OP_MARK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    len = (kind == SEG_LINES) ? $urandom_range(280, 330)
                                              : $urandom_range(258, 270);
                    repeat (len) begin
                        if (kind == SEG_LINES) begin
                            ch = ($urandom_range(0, 23) == 0) ? NEWLINE
                                                              : 8'($urandom_range(0, 255));
                        end else begin
                            ch = 8'($urandom_range(0, 254));
                            if (ch >= NEWLINE)
                                ch = ch + 8'd1;
                        end
                        eof = ($urandom_range(0, 29) == 0);
                        offer_item(OP_READ, ch, eof);
                    end
                    offer_item(OP_REPLAY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    fed_items = fed_items + len + 2;
                end
            endcase
            seg = seg + 1;
        end
        in_valid <= 1'b0;

        while (echoes.pending_echoes.size() != 0) @(posedge clk);
        // catch any stray item after the last one
        repeat (2 * BUF_DEPTH + 8) @(posedge clk);
        if (echoes.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Receiver: random stall after each item, quiet stretches, one long hold
    initial begin
        int unsigned stall_left;
        int unsigned seen;
        bit          eager_receiver;
        stall_left     = 0;
        seen           = 0;
        eager_receiver = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && !out_stall) begin
                echoes.check_output_item(out_data);
                seen = seen + 1;
                if (seen % 40 == 0)
                    eager_receiver = ($urandom_range(0, 2) == 0);
                stall_left = eager_receiver ? 0 : $urandom_range(0, 18);
            end else if (stall_left != 0) begin
                stall_left = stall_left - 1;
            end
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                stall_left       = HOLD_OFF_CYCLES;
            end
            out_stall <= (stall_left != 0);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
